// ----- hdl/c39_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39_pkg
// Shared types, register indexes, reset values and the Code 39 symbol table
// for the bar element encoder.
// ----------------------------------------------------------------------------
package c39_pkg;

    // Configuration register indexes
    localparam logic [7:0] REG_START_COLUMN = 8'd0;
    localparam logic [7:0] REG_NARROW_WIDTH = 8'd1;
    localparam logic [7:0] REG_WIDE_WIDTH   = 8'd2;
    localparam logic [7:0] REG_GAP_WIDTH    = 8'd3;

    // Register reset values
    localparam logic [15:0] START_RESET  = 16'd20;
    localparam logic [3:0]  NARROW_RESET = 4'd1;
    localparam logic [3:0]  WIDE_RESET   = 4'd3;
    localparam logic [5:0]  GAP_RESET    = 6'd6;

    // Element index of the inter-character gap (tenth element)
    localparam logic [3:0] LAST_ELEM_IDX = 4'd9;

    // Nine elements, bit 8 first; 1 = wide
    typedef logic [8:0] pat_t;

    typedef struct packed {
        logic [15:0] start_column;
        logic [3:0]  narrow_width;
        logic [3:0]  wide_width;
        logic [5:0]  gap_width;
    } cfg_t;

    typedef struct packed {
        logic known;
        pat_t pat;
    } lookup_t;

    // Item held between the input register and the element sequencer
    typedef struct packed {
        logic known;
        logic first;
        pat_t pat;
    } item_t;

    // Map a character to its Code 39 pattern
    function automatic lookup_t sym_lookup(input logic [7:0] ch);
        lookup_t res;
        res.known = 1'b1;
        case (ch)
            8'h2A: res.pat = 9'h094;   // '*'
            8'h2D: res.pat = 9'h085;   // '-'
            8'h2E: res.pat = 9'h184;   // '.'
            8'h20: res.pat = 9'h0C4;   // ' '
            8'h24: res.pat = 9'h0A8;   // '$'
            8'h2F: res.pat = 9'h0A2;   // '/'
            8'h2B: res.pat = 9'h08A;   // '+'
            8'h25: res.pat = 9'h02A;   // '%'
            8'h41: res.pat = 9'h109;
            8'h42: res.pat = 9'h049;
            8'h43: res.pat = 9'h148;
            8'h44: res.pat = 9'h019;
            8'h45: res.pat = 9'h118;
            8'h46: res.pat = 9'h058;
            8'h47: res.pat = 9'h00D;
            8'h48: res.pat = 9'h10C;
            8'h49: res.pat = 9'h04C;
            8'h4A: res.pat = 9'h01C;
            8'h4B: res.pat = 9'h103;
            8'h4C: res.pat = 9'h043;
            8'h4D: res.pat = 9'h142;
            8'h4E: res.pat = 9'h013;
            8'h4F: res.pat = 9'h112;
            8'h50: res.pat = 9'h052;
            8'h51: res.pat = 9'h007;
            8'h52: res.pat = 9'h106;
            8'h53: res.pat = 9'h046;
            8'h54: res.pat = 9'h016;
            8'h55: res.pat = 9'h181;
            8'h56: res.pat = 9'h0C1;
            8'h57: res.pat = 9'h1C0;
            8'h58: res.pat = 9'h091;
            8'h59: res.pat = 9'h190;
            8'h5A: res.pat = 9'h0D0;
            8'h30: res.pat = 9'h034;
            8'h31: res.pat = 9'h121;
            8'h32: res.pat = 9'h061;
            8'h33: res.pat = 9'h160;
            8'h34: res.pat = 9'h031;
            8'h35: res.pat = 9'h130;
            8'h36: res.pat = 9'h070;
            8'h37: res.pat = 9'h025;
            8'h38: res.pat = 9'h124;
            8'h39: res.pat = 9'h064;
            default:
            begin
                res.known = 1'b0;
                res.pat   = 9'h000;
            end
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/c39_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39 channel interfaces
// Character input, element output and configuration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface c39_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first_of_message;

    modport source (output valid, output char_code, output first_of_message, input ready);
    modport sink   (input valid, input char_code, input first_of_message, output ready);
endinterface

interface c39_elem_if;
    logic        valid;
    logic        ready;
    logic [15:0] elem_start;
    logic [5:0]  elem_width;
    logic        is_bar;
    logic        last_elem;

    modport source (output valid, output elem_start, output elem_width,
                    output is_bar, output last_elem, input ready);
    modport sink   (input valid, input elem_start, input elem_width,
                    input is_bar, input last_elem, output ready);
endinterface

interface c39_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/code39_bar_element_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code39_bar_element_encoder_core
// Code 39 encoder: turns each character into its nine bars and spaces plus
// the inter-character gap, with start column and width per element.
//
//   channel   modport   payload                                   role
//   char_in   sink      char_code, first_of_message               characters in
//   elem_out  source    elem_start, elem_width, is_bar, last_elem elements out
//   cfg       sink      index, data                               register writes
//
// A supported character yields ten elements, one element per cycle from the
// sequencer unless the output stalls; an unsupported one yields nothing.
// Each character passes the input register, then the output register.
// A new character is taken into the input register while the previous one
// is still being sequenced. A stalled output holds the sequencer.
// Reset loads the register reset values and sets the column to 20.
// ----------------------------------------------------------------------------
module code39_bar_element_encoder_core #(
    parameter int COLUMN_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    c39_char_if.sink  char_in,
    c39_elem_if.source elem_out,
    c39_cfg_if.sink   cfg
);

    c39_pkg::cfg_t  cfg_val;
    c39_pkg::item_t item;
    logic           item_valid;
    logic           item_pop;

    c39_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    c39_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    c39_elem_seq #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_val    (cfg_val),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .elem_out   (elem_out)
    );

endmodule

// ----- hdl/c39_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39_cfg_regs
// Configuration register file: start column and element widths.
// ----------------------------------------------------------------------------
module c39_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    c39_cfg_if.sink        cfg,
    output c39_pkg::cfg_t  cfg_val
);

    c39_pkg::cfg_t cfg_reg;

    // Always accept writes
    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    // Write the addressed register; drop indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_column <= c39_pkg::START_RESET;
            cfg_reg.narrow_width <= c39_pkg::NARROW_RESET;
            cfg_reg.wide_width   <= c39_pkg::WIDE_RESET;
            cfg_reg.gap_width    <= c39_pkg::GAP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                c39_pkg::REG_START_COLUMN: cfg_reg.start_column <= cfg.data;
                c39_pkg::REG_NARROW_WIDTH: cfg_reg.narrow_width <= cfg.data[3:0];
                c39_pkg::REG_WIDE_WIDTH:   cfg_reg.wide_width   <= cfg.data[3:0];
                c39_pkg::REG_GAP_WIDTH:    cfg_reg.gap_width    <= cfg.data[5:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/c39_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39_in_stage
// Input register: takes a character, looks up its pattern and holds the item
// until the element sequencer pops it.
// ----------------------------------------------------------------------------
module c39_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    c39_char_if.sink       char_in,
    output c39_pkg::item_t item,
    output logic           item_valid,
    input  logic           item_pop
);

    logic             in_valid_reg;
    logic             in_valid_next;
    c39_pkg::item_t   item_reg;
    c39_pkg::lookup_t lut;
    logic             accept;

    // Free when empty or when the held item leaves this cycle
    assign char_in.ready = !in_valid_reg || item_pop;
    assign accept        = char_in.valid && char_in.ready;
    assign lut           = c39_pkg::sym_lookup(char_in.char_code);
    assign item          = item_reg;
    assign item_valid    = in_valid_reg;

    // Track occupancy
    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (item_pop)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Capture the looked-up item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.known <= lut.known;
            item_reg.first <= char_in.first_of_message;
            item_reg.pat   <= lut.pat;
        end
    end

    // Held item stays until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !item_pop |=> in_valid_reg)
        else $error("input item lost before pop");

    // Every known symbol has exactly three wide elements
    a_pat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && item_reg.known |-> $countones(item_reg.pat) == 3)
        else $error("known item with malformed pattern");

    // Pop only a held item
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> in_valid_reg)
        else $error("pop with no item held");

endmodule

// ----- hdl/c39_elem_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39_elem_seq
// Element sequencer: steps through the nine bars and spaces and the gap of
// one character, one element per cycle while the output is not stalled, keeping the running column.
// ----------------------------------------------------------------------------
module c39_elem_seq #(
    parameter int COLUMN_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  c39_pkg::cfg_t  cfg_val,
    input  c39_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_pop,
    c39_elem_if.source     elem_out
);

    localparam int SW = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_INIT = COLUMN_BITS'(c39_pkg::START_RESET);

    logic                   busy_reg, busy_next;
    logic [3:0]             idx_reg, idx_next;
    c39_pkg::pat_t          pat_reg, pat_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   out_valid_reg, out_valid_next;
    logic [15:0]            start_out_reg;
    logic [5:0]             width_out_reg;
    logic                   bar_out_reg;
    logic                   last_out_reg;

    logic                   out_free;
    logic                   emit;
    logic [SW-1:0]          start_ext;
    logic [COLUMN_BITS-1:0] start_sat;
    logic [COLUMN_BITS-1:0] base_col;
    c39_pkg::pat_t          src_pat;
    c39_pkg::pat_t          pat_shift;
    logic [3:0]             src_idx;
    logic [COLUMN_BITS-1:0] src_col;
    logic                   is_gap;
    logic [5:0]             width;
    logic                   bar;
    logic [COLUMN_BITS:0]   col_sum;
    logic [COLUMN_BITS-1:0] col_adv;

    assign out_free = !out_valid_reg || elem_out.ready;

    // Saturate the start column into the column range
    assign start_ext = SW'(cfg_val.start_column);
    assign start_sat = (start_ext > SW'(COL_MAX)) ? COL_MAX : COLUMN_BITS'(start_ext);
    assign base_col  = item.first ? start_sat : col_reg;

    // Pick the element source: the running character or a fresh one
    always_comb
    begin
        emit     = 1'b0;
        item_pop = 1'b0;
        src_pat  = pat_reg;
        src_idx  = idx_reg;
        src_col  = col_reg;
        if (busy_reg)
        begin
            emit = out_free;
        end
        else if (item_valid)
        begin
            item_pop = item.known ? out_free : 1'b1;
            emit     = item.known && out_free;
            src_pat  = item.pat;
            src_idx  = 4'd0;
            src_col  = base_col;
        end
    end

    // Width, bar flag and column advance of the current element
    assign is_gap    = (src_idx == c39_pkg::LAST_ELEM_IDX);
    assign pat_shift = src_pat << src_idx;
    assign width     = is_gap ? cfg_val.gap_width
                     : (pat_shift[8] ? {2'b00, cfg_val.wide_width}
                                     : {2'b00, cfg_val.narrow_width});
    assign bar       = !is_gap && !src_idx[0];
    assign col_sum   = {1'b0, src_col} + (COLUMN_BITS+1)'(width);
    assign col_adv   = col_sum[COLUMN_BITS] ? COL_MAX : col_sum[COLUMN_BITS-1:0];

    // Next state of the sequencer and output register
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        pat_next       = pat_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !elem_out.ready;
        if (emit)
        begin
            busy_next      = !is_gap;
            idx_next       = src_idx + 4'd1;
            pat_next       = src_pat;
            col_next       = col_adv;
            out_valid_next = 1'b1;
        end
        else if (item_pop)
        begin
            col_next = base_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
            col_reg       <= COL_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load pattern and result payload
    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
        if (emit)
        begin
            start_out_reg <= 16'(SW'(src_col));
            width_out_reg <= width;
            bar_out_reg   <= bar;
            last_out_reg  <= is_gap;
        end
    end

    assign elem_out.valid      = out_valid_reg;
    assign elem_out.elem_start = start_out_reg;
    assign elem_out.elem_width = width_out_reg;
    assign elem_out.is_bar     = bar_out_reg;
    assign elem_out.last_elem  = last_out_reg;

    // A running character sits between its first and last element
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg != 4'd0 && idx_reg <= c39_pkg::LAST_ELEM_IDX)
        else $error("element index out of range");

    // The gap ends the character
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        emit && is_gap |=> !busy_reg)
        else $error("sequencer still busy after gap");

    // The column only moves forward within a character
    a_mono: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && $past(busy_reg) |-> col_reg >= $past(col_reg))
        else $error("column moved backward");

endmodule

// ----- tb/code39_bar_element_encoder_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code39_bar_element_encoder_core_test
// Self-checking bench for the Code 39 bar element encoder. Characters go in
// over the char channel and a local column model predicts every bar, space
// and gap. Each element taken from the output channel is compared field by
// field against the oldest prediction. The run covers the reset state,
// unknown characters, column saturation, zero widths and stray register
// writes. A long output hold-off fills the block up. Random messages then
// run under four pacing phases, each with its own register settings.
// ----------------------------------------------------------------------------
module code39_bar_element_encoder_core_test;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int BAR_COUNT      = 9;
    localparam int SYM_COUNT      = 44;
    localparam logic [16:0] COL_MAX    = 17'h0FFFF;
    localparam logic [7:0]  START_STOP = 8'h2A;

    // Symbols and their patterns in matching order; bit 8 is the first element
    localparam logic [SYM_COUNT*8-1:0] SYM_CHARS =
        "*-. $/+%ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    localparam logic [SYM_COUNT*9-1:0] SYM_PATS = {
        9'h094, 9'h085, 9'h184, 9'h0C4, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A,
        9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C,
        9'h04C, 9'h01C, 9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052,
        9'h007, 9'h106, 9'h046, 9'h016, 9'h181, 9'h0C1, 9'h1C0, 9'h091,
        9'h190, 9'h0D0, 9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130,
        9'h070, 9'h025, 9'h124, 9'h064
    };

    typedef struct packed {
        logic [15:0] first_col;
        logic [5:0]  width;
        logic        bar;
        logic        gap;
    } elem_t;

    logic clk = 1'b0;
    logic rst_n;

    c39_char_if char_bus ();
    c39_elem_if elem_bus ();
    c39_cfg_if  cfg_bus ();

    code39_bar_element_encoder_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .elem_out (elem_bus),
        .cfg      (cfg_bus)
    );

    // Register mirror and running column, at their reset values
    logic [15:0] cfg_start  = 16'd20;
    logic [3:0]  cfg_narrow = 4'd1;
    logic [3:0]  cfg_wide   = 4'd3;
    logic [5:0]  cfg_gap    = 6'd6;
    logic [16:0] column_pos = 17'd20;

    elem_t expected_elems[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_off     = 1'b0;
    event holdoff_go;

    int error_count     = 0;
    int chars_sent      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles, %0d elements still due",
                     $time, cycle_count, expected_elems.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Column model
    // ------------------------------------------------------------------
    function automatic bit find_pattern(input logic [7:0] ch, output logic [8:0] pat);
        int i;
        pat = '0;
        for (i = 0; i < SYM_COUNT; i++)
        begin
            if (SYM_CHARS[(SYM_COUNT-1-i)*8 +: 8] == ch)
            begin
                pat = SYM_PATS[(SYM_COUNT-1-i)*9 +: 9];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Queue one element and advance the column, saturating at the top
    function automatic void push_elem(input logic [5:0] w, input logic bar,
                                      input logic gap);
        elem_t el;
        logic [16:0] sum;
        el.first_col = column_pos[15:0];
        el.width     = w;
        el.bar       = bar;
        el.gap       = gap;
        expected_elems.push_back(el);
        sum = column_pos + 17'(w);
        column_pos = (sum > COL_MAX) ? COL_MAX : sum;
    endfunction

    function automatic void predict_elements(input logic [7:0] ch, input logic first);
        logic [8:0] pat;
        int e;
        // A message start reloads the column even for an unknown character
        if (first)
            column_pos = {1'b0, cfg_start};
        if (!find_pattern(ch, pat))
            return;
        for (e = 0; e < BAR_COUNT; e++)
            push_elem({2'b00, pat[BAR_COUNT-1-e] ? cfg_wide : cfg_narrow},
                      (e % 2) == 0, 1'b0);
        push_elem(cfg_gap, 1'b0, 1'b1);
    endfunction

    function automatic logic [7:0] random_symbol();
        return SYM_CHARS[$urandom_range(SYM_COUNT-1)*8 +: 8];
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    // Offer one character, idling at random first; valid stays high after
    task automatic send_char(input logic [7:0] ch, input logic first);
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            if (!lowered)
            begin
                char_bus.valid <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge clk);
        end
        char_bus.valid            <= 1'b1;
        char_bus.char_code        <= ch;
        char_bus.first_of_message <= first;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        predict_elements(ch, first);
        chars_sent++;
    endtask

    // Write one register; valid stays high until cfg_release
    task automatic write_reg(input logic [7:0] reg_idx, input logic [15:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= reg_idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        reg_writes++;
        case (reg_idx)
            c39_pkg::REG_START_COLUMN: cfg_start  = data;
            c39_pkg::REG_NARROW_WIDTH: cfg_narrow = data[3:0];
            c39_pkg::REG_WIDE_WIDTH:   cfg_wide   = data[3:0];
            c39_pkg::REG_GAP_WIDTH:    cfg_gap    = data[5:0];
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        cfg_bus.valid <= 1'b0;
    endtask

    // Drop the char channel and wait until every element has come out
    task automatic wait_idle();
        char_bus.valid <= 1'b0;
        while (expected_elems.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers, with junk in the unused upper data bits
    task automatic configure(input logic [15:0] start, input logic [3:0] nw,
                             input logic [3:0] ww, input logic [5:0] gw);
        wait_idle();
        write_reg(c39_pkg::REG_START_COLUMN, start);
        write_reg(c39_pkg::REG_NARROW_WIDTH,
                  (16'($urandom) & 16'hFFF0) | {12'h000, nw});
        write_reg(c39_pkg::REG_WIDE_WIDTH,
                  (16'($urandom) & 16'hFFF0) | {12'h000, ww});
        write_reg(c39_pkg::REG_GAP_WIDTH,
                  (16'($urandom) & 16'hFFC0) | {10'h000, gw});
        cfg_release();
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pacing, hold-off and element checker
    // ------------------------------------------------------------------
    initial
    begin : elem_ready_driver
        elem_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            elem_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : receiver_holdoff
        int held;
        forever
        begin
            @(holdoff_go);
            hold_off <= 1'b1;
            for (held = 0; held < HOLDOFF_CYCLES; held++)
                @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : elem_checker
        elem_t want;
        if (rst_n && elem_bus.valid && elem_bus.ready)
        begin
            if (expected_elems.size() == 0)
            begin
                $display("%0t ns: unexpected element, expected none, actual %0d/%0d/%0d/%0d",
                         $time, elem_bus.elem_start, elem_bus.elem_width,
                         elem_bus.is_bar, elem_bus.last_elem);
                error_count++;
            end
            else
            begin
                want = expected_elems.pop_front();
                compare_field("elem_start", want.first_col, elem_bus.elem_start);
                compare_field("elem_width", 16'(want.width), 16'(elem_bus.elem_width));
                compare_field("is_bar", 16'(want.bar), 16'(elem_bus.is_bar));
                compare_field("last_elem", 16'(want.gap), 16'(elem_bus.last_elem));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Registers and column as left by reset
    task automatic test_reset_state();
        send_char(START_STOP, 1'b0);
        send_char("A", 1'b0);
        send_char("0", 1'b1);
    endtask

    // Unknown codes emit nothing; a message start on one still reloads
    task automatic test_unknown_chars();
        configure(16'd100, 4'd2, 4'd5, 6'd10);
        send_char("Z", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char("a", 1'b0);
        send_char("9", 1'b0);
    endtask

    // Widest elements near the top of the column range
    task automatic test_column_saturation();
        configure(16'd65500, 4'd15, 4'd15, 6'd63);
        send_char("W", 1'b1);
        send_char("%", 1'b0);
        send_char(".", 1'b0);
        configure(16'hFFFF, 4'd15, 4'd1, 6'd63);
        send_char(START_STOP, 1'b1);
    endtask

    // Zero widths are reported as they are
    task automatic test_zero_widths();
        configure(16'd0, 4'd0, 4'd0, 6'd0);
        send_char("M", 1'b1);
        send_char("-", 1'b0);
        configure(16'd0, 4'd0, 4'd15, 6'd0);
        send_char(" ", 1'b1);
        send_char("$", 1'b0);
    endtask

    // Writes past the last register change nothing
    task automatic test_stray_registers();
        configure(16'd20, 4'd1, 4'd3, 6'd6);
        @(posedge clk);
        write_reg(8'd4, 16'hFFFF);
        write_reg(8'hFF, 16'h0000);
        write_reg(8'hAA, 16'($urandom));
        cfg_release();
        send_char("+", 1'b1);
        send_char("/", 1'b0);
    endtask

    // Hold the output off while characters keep coming, so the input stalls
    task automatic test_output_backpressure();
        int k;
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> holdoff_go;
        for (k = 0; k < 10; k++)
            send_char(random_symbol(), k == 0);
        wait_idle();
    endtask

    // Random messages under one pacing setting, with fresh registers first
    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int phase_items, input int setting);
        int sent;
        int len;
        int k;
        case (setting)
            0: configure(16'd20, 4'd1, 4'd3, 6'd6);
            1: configure(16'($urandom), 4'($urandom_range(15)), 4'($urandom_range(15)),
                         6'($urandom_range(63)));
            2: configure(16'(32'hFFFF - $urandom_range(600)), 4'($urandom_range(1, 15)),
                         4'($urandom_range(1, 15)), 6'($urandom_range(63)));
            default: configure(16'd0, 4'd15, 4'd15, 6'd63);
        endcase
        @(posedge clk);
        write_reg(8'($urandom_range(4, 255)), 16'($urandom));
        cfg_release();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < phase_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                // Noise: any code, any message flag
                send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else
            begin
                // Framed message, now and then missing its stop symbol
                len = $urandom_range(6);
                send_char(START_STOP, 1'b1);
                for (k = 0; k < len; k++)
                    send_char(random_symbol(), 1'b0);
                if ($urandom_range(9) != 0)
                    send_char(START_STOP, 1'b0);
                sent += len + 2;
            end
        end
        wait_idle();
    endtask

    initial
    begin : test_sequence
        rst_n                     = 1'b0;
        char_bus.valid            = 1'b0;
        char_bus.char_code        = 8'h00;
        char_bus.first_of_message = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = 8'h00;
        cfg_bus.data              = 16'h0000;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_unknown_chars();
        test_column_saturation();
        test_zero_widths();
        test_stray_registers();
        test_output_backpressure();
        test_random_phase(0, 0, 80, 0);
        test_random_phase(56, 0, 80, 1);
        test_random_phase(0, 56, 80, 2);
        test_random_phase(30, 30, 80, 3);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d characters, checked %0d elements, made %0d register writes;",
                 chars_sent, results_checked, reg_writes);
        $display("covered reset state, unknown codes, saturation, zero widths, hold-off, 4 pacings.");
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
